/* rtl/core/snrw_pkg.sv */
// Shared types, constants and helpers for the snapshot ring rewind controller.
`default_nettype none
package snrw_pkg;

   localparam int BUTTONS_W              = 11;
   localparam int BUTTON_COUNT           = 11;
   localparam int CAPTURE_INTERVAL_DEFAULT = 30;
   localparam int BTN_IDX_W              = 5;
   localparam int SLOT_W                 = 6;
   localparam int ACTION_W               = 2;
   localparam int CSR_INDEX_W            = 3;
   localparam int CSR_DATA_W             = 5;
   localparam int REQ_TDATA_W            = 16;
   localparam int RSP_TDATA_W            = 24;

   // Buttons past the mask width can never be pressed.
   localparam int BUTTON_LIMIT = (BUTTON_COUNT < BUTTONS_W) ? BUTTON_COUNT : BUTTONS_W;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_TOGGLE_FF     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_FF       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TOGGLE_REWIND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_REWIND   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RING_SIZE     = 3'd4;

   // Snapshot commands.
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SAVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd2;

   typedef struct packed {
      logic signed [BTN_IDX_W-1:0] toggle_ff_button;
      logic signed [BTN_IDX_W-1:0] hold_ff_button;
      logic signed [BTN_IDX_W-1:0] toggle_rewind_button;
      logic signed [BTN_IDX_W-1:0] hold_rewind_button;
      logic [1:0]                  ring_size_setting;
   } cfg_type;

   typedef struct packed {
      logic fast_forward;
      logic speed_changed;
      logic rewinding;
   } speed_type;

   typedef struct packed {
      logic [ACTION_W-1:0] snapshot_action;
      logic [SLOT_W-1:0]   snapshot_slot;
      logic [SLOT_W-1:0]   filled_slots;
   } ring_type;

   function automatic logic [SLOT_W-1:0] ring_slots(input logic [1:0] setting);
      logic [SLOT_W-1:0] slots;
      case (setting)
         2'd1:    slots = 6'd10;
         2'd2:    slots = 6'd30;
         2'd3:    slots = 6'd60;
         default: slots = 6'd0;
      endcase
      return slots;
   endfunction

   // A negative index or one past the button range reads as not pressed.
   function automatic logic btn_bit(input logic [BUTTONS_W-1:0] mask,
                                    input logic signed [BTN_IDX_W-1:0] b);
      logic [BUTTONS_W-1:0] shifted;
      logic                 in_range;
      shifted  = mask >> b[BTN_IDX_W-2:0];
      in_range = !b[BTN_IDX_W-1] &&
                 ({1'b0, b[BTN_IDX_W-2:0]} < BTN_IDX_W'(BUTTON_LIMIT));
      return in_range & shifted[0];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/snrw_csr.sv */
// Configuration register bank written over the csr channel.
`default_nettype none
module snrw_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [snrw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [snrw_pkg::CSR_DATA_W-1:0]    csr_data,
   output snrw_pkg::cfg_type                       cfg
);
   import snrw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TOGGLE_FF:     cfg_in.toggle_ff_button     = csr_data;
            REG_HOLD_FF:       cfg_in.hold_ff_button       = csr_data;
            REG_TOGGLE_REWIND: cfg_in.toggle_rewind_button = csr_data;
            REG_HOLD_REWIND:   cfg_in.hold_rewind_button   = csr_data;
            REG_RING_SIZE:     cfg_in.ring_size_setting    = csr_data[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.toggle_ff_button     <= '1;
         cfg_ff.hold_ff_button       <= '1;
         cfg_ff.toggle_rewind_button <= '1;
         cfg_ff.hold_rewind_button   <= '1;
         cfg_ff.ring_size_setting    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/snrw_speed.sv */
// Fast-forward and rewind mode flags driven by button edges and levels.
`default_nettype none
module snrw_speed (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [snrw_pkg::BUTTONS_W-1:0]    buttons,
   input  snrw_pkg::cfg_type                      cfg,
   output snrw_pkg::speed_type                    speed
);
   import snrw_pkg::*;

   logic [BUTTONS_W-1:0] prev_ff;
   logic ff_active_ff, ff_toggled_ff, ff_hold_ff;
   logic rw_active_ff, rw_toggled_ff, rw_hold_ff;
   logic ff_active_in, ff_toggled_in, ff_hold_in;
   logic rw_active_in, rw_toggled_in, rw_hold_in;
   logic ff_held, rw_held;

   assign ff_held = btn_bit(buttons, cfg.hold_ff_button);
   assign rw_held = btn_bit(buttons, cfg.hold_rewind_button);

   always_comb begin
      ff_active_in  = ff_active_ff;
      ff_toggled_in = ff_toggled_ff;
      ff_hold_in    = ff_hold_ff;
      rw_active_in  = rw_active_ff;
      rw_toggled_in = rw_toggled_ff;
      rw_hold_in    = rw_hold_ff;

      if (btn_bit(buttons, cfg.toggle_ff_button) && !btn_bit(prev_ff, cfg.toggle_ff_button)) begin
         ff_toggled_in = !ff_toggled_in;
         ff_active_in  = ff_toggled_in;
      end
      if (!cfg.hold_ff_button[BTN_IDX_W-1]) begin
         if (ff_held && !ff_hold_in) begin
            ff_hold_in   = 1'b1;
            ff_active_in = 1'b1;
         end else if (!ff_held && ff_hold_in) begin
            ff_hold_in   = 1'b0;
            ff_active_in = ff_toggled_in;
         end
      end

      // Engaging rewind always forces fast-forward off.
      if (btn_bit(buttons, cfg.toggle_rewind_button) &&
          !btn_bit(prev_ff, cfg.toggle_rewind_button)) begin
         rw_toggled_in = !rw_toggled_in;
         rw_active_in  = rw_toggled_in;
         if (rw_active_in) begin
            ff_active_in = 1'b0;
         end
      end
      if (!cfg.hold_rewind_button[BTN_IDX_W-1]) begin
         if (rw_held && !rw_hold_in) begin
            rw_hold_in   = 1'b1;
            rw_active_in = 1'b1;
            ff_active_in = 1'b0;
         end else if (!rw_held && rw_hold_in) begin
            rw_hold_in   = 1'b0;
            rw_active_in = rw_toggled_in;
            if (!rw_active_in && ff_toggled_in) begin
               ff_active_in = 1'b1;
            end
         end
      end
      if (!rw_active_in && !rw_hold_in && ff_toggled_in && !ff_active_in) begin
         ff_active_in = 1'b1;
      end
   end

   assign speed.fast_forward  = ff_active_in;
   assign speed.speed_changed = ff_active_in ^ ff_active_ff;
   assign speed.rewinding     = rw_active_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         ff_active_ff  <= 1'b0;
         ff_toggled_ff <= 1'b0;
         ff_hold_ff    <= 1'b0;
         rw_active_ff  <= 1'b0;
         rw_toggled_ff <= 1'b0;
         rw_hold_ff    <= 1'b0;
      end else if (advance) begin
         prev_ff       <= buttons;
         ff_active_ff  <= ff_active_in;
         ff_toggled_ff <= ff_toggled_in;
         ff_hold_ff    <= ff_hold_in;
         rw_active_ff  <= rw_active_in;
         rw_toggled_ff <= rw_toggled_in;
         rw_hold_ff    <= rw_hold_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/snrw_ring.sv */
// Snapshot ring head, fill count and capture frame counter.
`default_nettype none
module snrw_ring #(
   parameter int CAPTURE_INTERVAL = snrw_pkg::CAPTURE_INTERVAL_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        rewinding,
   input  wire logic [1:0]  ring_size_setting,
   output snrw_pkg::ring_type ring
);
   import snrw_pkg::*;

   localparam int FC_W = (CAPTURE_INTERVAL > 1) ? $clog2(CAPTURE_INTERVAL + 1) : 1;

   logic [1:0]        applied_ff, applied_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [FC_W-1:0]   fc_ff, fc_in, fc_inc;
   logic [SLOT_W-1:0] slots;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0] slot;

   assign fc_inc = fc_ff + 1'b1;

   always_comb begin
      applied_in = applied_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      fc_in      = fc_ff;
      action     = ACT_NONE;
      slot       = '0;

      // A new ring size empties the ring but keeps the frame counter.
      if (ring_size_setting != applied_ff) begin
         applied_in = ring_size_setting;
         head_in    = '0;
         count_in   = '0;
      end
      slots = ring_slots(applied_in);

      if (rewinding) begin
         if ((slots != '0) && (count_in != '0)) begin
            head_in  = (head_in == '0) ? slots - 1'b1 : head_in - 1'b1;
            count_in = count_in - 1'b1;
            action   = ACT_LOAD;
            slot     = head_in;
         end
      end else if (slots != '0) begin
         if (fc_inc >= FC_W'(CAPTURE_INTERVAL)) begin
            fc_in   = '0;
            action  = ACT_SAVE;
            slot    = head_in;
            head_in = (head_in == slots - 1'b1) ? '0 : head_in + 1'b1;
            if (count_in < slots) begin
               count_in = count_in + 1'b1;
            end
         end else begin
            fc_in = fc_inc;
         end
      end
   end

   assign ring.snapshot_action = action;
   assign ring.snapshot_slot   = slot;
   assign ring.filled_slots    = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff <= '0;
         head_ff    <= '0;
         count_ff   <= '0;
         fc_ff      <= '0;
      end else if (advance) begin
         applied_ff <= applied_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         fc_ff      <= fc_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/snapshot_ring_rewind_controller.sv */
// Top level of the snapshot ring rewind controller: input and result registers.
//
//  Channel  Direction  Handshake              Payload
//  req_     in         req_tvalid/req_tready  req_tdata: buttons
//  rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata: speed and snapshot command
//  csr_     in         csr_valid/csr_ready    csr_index, csr_data
//
// Each frame beat is latched in an input register, processed combinationally and
// lands in a result register; one beat per cycle is sustained while rsp_tready
// is high. The mode flags and ring counters advance as the beat moves into the
// result register. When rsp_tready is low, the result and input registers hold
// and req_tready drops once both are full. Reset clears all state but the data
// registers; configuration writes are taken in every cycle.
`default_nettype none
module snapshot_ring_rewind_controller #(
   parameter int CAPTURE_INTERVAL = snrw_pkg::CAPTURE_INTERVAL_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [10:0] buttons
   input  wire logic [snrw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] fast_forward, [1] speed_changed, [3:2] snapshot_action,
   // [9:4] snapshot_slot, [10] rewinding, [16:11] filled_slots
   output logic [snrw_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [snrw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [snrw_pkg::CSR_DATA_W-1:0]     csr_data
);
   import snrw_pkg::*;

   localparam int RSP_USED_W = 3 + ACTION_W + 2 * SLOT_W;

   cfg_type   cfg;
   speed_type speed;
   ring_type  ring;

   logic                   in_valid_ff;
   logic [BUTTONS_W-1:0]   in_buttons_ff;
   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff;
   logic                   advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   snrw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   snrw_speed u_speed (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .buttons (in_buttons_ff),
      .cfg     (cfg),
      .speed   (speed)
   );

   snrw_ring #(
      .CAPTURE_INTERVAL (CAPTURE_INTERVAL)
   ) u_ring (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .rewinding         (speed.rewinding),
      .ring_size_setting (cfg.ring_size_setting),
      .ring              (ring)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_buttons_ff <= req_tdata[BUTTONS_W-1:0];
      end
      if (advance) begin
         out_data_ff <= {{(RSP_TDATA_W - RSP_USED_W){1'b0}},
                         ring.filled_slots, speed.rewinding, ring.snapshot_slot,
                         ring.snapshot_action, speed.speed_changed, speed.fast_forward};
      end
   end

endmodule
`default_nettype wire
